### sv/assert_macros.svh
// Assertion macros used by the port checker of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition b at the same clock edge.
`define ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("assertion failed: same-cycle implication");

// Condition a implies condition b at the next clock edge.
`define ASSERT_NXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/nsc_pkg.sv
// Types and constants for the NMEA sentence checksum checker.
// No dependencies.
package nsc_pkg;

    localparam logic [6:0] MAX_LEN    = 7'd80;
    localparam logic [6:0] COUNT_MAX  = 7'd127;
    localparam logic [7:0] NEWLINE    = 8'd10;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_LOW_A = 8'd97;
    localparam logic [7:0] CHAR_UP_A  = 8'd65;

    localparam logic [7:0] START_RESET  = 8'd36;
    localparam logic [7:0] END_RESET    = 8'd42;
    localparam logic       SOURCE_RESET = 1'b0;

    localparam logic [1:0] REG_START  = 2'd0;
    localparam logic [1:0] REG_END    = 2'd1;
    localparam logic [1:0] REG_SOURCE = 2'd2;

    typedef enum logic [1:0] {
        STATUS_VALID    = 2'd0,
        STATUS_GPS_ERR  = 2'd1,
        STATUS_CTRL_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic       source_kind;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] char_in;
        logic       last_char;
    } item_t;

endpackage

### sv/nmea_sentence_checksum_checker.sv
// NMEA sentence checksum checker, top level.
// A result word is registered after its last character has passed from the input register into the core.
// Throughput: one character per cycle. A waiting result holds the core, so the
// input register takes one more word and then stalls until the result is read.
// Reset: synchronous active-low aresetn clears the sentence state and valids
// and restores the markers to '$' and '*' and the source kind to GPS.
module nmea_sentence_checksum_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_computed_sum,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import nsc_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  take;

    nsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nsc_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_last_char (s_last_char),
        .take        (take),
        .item        (item)
    );

    nsc_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item           (item),
        .cfg            (cfg),
        .take           (take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_computed_sum (m_computed_sum)
    );

endmodule

### sv/nsc_cfg_regs.sv
// Configuration registers of the checksum checker.
// Depends on nsc_pkg.
module nsc_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output nsc_pkg::cfg_t cfg
);
    import nsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_START:  cfg_next.start_marker = cfg_data;
                REG_END:    cfg_next.end_marker   = cfg_data;
                REG_SOURCE: cfg_next.source_kind  = cfg_data[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker <= START_RESET;
            cfg_reg.end_marker   <= END_RESET;
            cfg_reg.source_kind  <= SOURCE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/nsc_in_stage.sv
// Input register of the checksum checker: holds one character for the core.
// Depends on nsc_pkg.
module nsc_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [7:0]     s_char_in,
    input  logic           s_last_char,
    input  logic           take,
    output nsc_pkg::item_t item
);
    import nsc_pkg::*;

    item_t item_reg;
    logic  load;

    assign s_ready = !item_reg.valid || take;
    assign load    = s_valid && s_ready;
    assign item    = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (load) begin
            item_reg.valid <= 1'b1;
        end else if (take) begin
            item_reg.valid <= 1'b0;
        end
        if (load) begin
            item_reg.char_in   <= s_char_in;
            item_reg.last_char <= s_last_char;
        end
    end

endmodule

### sv/nsc_core.sv
// Sentence state, checksum decision and result register of the checker.
// Depends on nsc_pkg.
module nsc_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  nsc_pkg::item_t item,
    input  nsc_pkg::cfg_t  cfg,
    output logic           take,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [7:0]     m_computed_sum
);
    import nsc_pkg::*;

    logic [6:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic       start_reg, start_next;
    logic       end_reg, end_next;
    logic       tail_reg, tail_next;
    logic [1:0] tcnt_reg, tcnt_next;
    logic [3:0] hi_reg, hi_next;
    logic [3:0] lo_reg, lo_next;
    logic       mvalid_reg, mvalid_next;
    status_t    status_reg, status_next;
    logic [7:0] msum_reg;

    logic       fire;
    logic       is_start;
    logic       is_end;
    logic [3:0] prev_digit;
    logic [3:0] digit;
    logic       bad;

    function automatic logic [3:0] decode_digit(input logic [7:0] c, input logic [3:0] prev);
        logic [7:0] d;
        d = {4'd0, prev};
        if (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_A + 8'd5) begin
            d = c - CHAR_LOW_A + 8'd10;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_A + 8'd5) begin
            d = c - CHAR_UP_A + 8'd10;
        end
        return d[3:0];
    endfunction

    // The result register frees up when it is empty or being read.
    assign take = !mvalid_reg || m_ready;
    assign fire = item.valid && take;

    assign is_start = (cfg.start_marker != 8'd0) && (item.char_in == cfg.start_marker);
    assign is_end   = (cfg.end_marker != 8'd0) && (item.char_in == cfg.end_marker);

    // The second digit falls back on the first; the first falls back on zero.
    assign prev_digit = (tcnt_reg == 2'd0) ? 4'd0 : hi_reg;
    assign digit      = decode_digit(item.char_in, prev_digit);

    always_comb begin
        count_next = (count_reg < COUNT_MAX) ? count_reg + 7'd1 : count_reg;
        start_next = start_reg || is_start;
        end_next   = end_reg || is_end;
        tail_next  = tail_reg;
        sum_next   = sum_reg;
        tcnt_next  = tcnt_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (!tail_reg) begin
            if (is_end || item.char_in == NEWLINE) begin
                tail_next = 1'b1;
            end else if (!is_start) begin
                sum_next = sum_reg ^ item.char_in;
            end
        end else if (tcnt_reg < 2'd2) begin
            if (tcnt_reg == 2'd0) begin
                hi_next = digit;
            end else begin
                lo_next = digit;
            end
            tcnt_next = tcnt_reg + 2'd1;
        end

        bad = (count_next > MAX_LEN) || !start_next || !end_next || !tail_next
              || (tcnt_next < 2'd2) || ({hi_next, lo_next} != sum_next);
        if (!bad) begin
            status_next = STATUS_VALID;
        end else if (cfg.source_kind) begin
            status_next = STATUS_CTRL_ERR;
        end else begin
            status_next = STATUS_GPS_ERR;
        end

        mvalid_next = take ? (fire && item.last_char) : mvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 7'd0;
            sum_reg    <= 8'd0;
            start_reg  <= 1'b0;
            end_reg    <= 1'b0;
            tail_reg   <= 1'b0;
            tcnt_reg   <= 2'd0;
            hi_reg     <= 4'd0;
            lo_reg     <= 4'd0;
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
            if (fire) begin
                if (item.last_char) begin
                    count_reg <= 7'd0;
                    sum_reg   <= 8'd0;
                    start_reg <= 1'b0;
                    end_reg   <= 1'b0;
                    tail_reg  <= 1'b0;
                    tcnt_reg  <= 2'd0;
                    hi_reg    <= 4'd0;
                    lo_reg    <= 4'd0;
                end else begin
                    count_reg <= count_next;
                    sum_reg   <= sum_next;
                    start_reg <= start_next;
                    end_reg   <= end_next;
                    tail_reg  <= tail_next;
                    tcnt_reg  <= tcnt_next;
                    hi_reg    <= hi_next;
                    lo_reg    <= lo_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && item.last_char) begin
            status_reg <= status_next;
            msum_reg   <= sum_next;
        end
    end

    assign m_valid        = mvalid_reg;
    assign m_status       = status_reg;
    assign m_computed_sum = msum_reg;

endmodule

### sv/nsc_port_checker.sv
// Port-level assertions for the checksum checker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module nsc_port_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [7:0] m_computed_sum,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    logic [9:0] m_word;

    assign m_word = {m_status, m_computed_sum};

    // A stalled result holds its word.
    `ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_word))

    // The input only stalls when a result is waiting downstream.
    `ASSERT_IMP(a_stall, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // Status code three is never produced.
    `ASSERT_IMP(a_code, aclk, aresetn, m_valid, m_status != 2'd3)

    // Configuration writes are never held off.
    `ASSERT_IMP(a_cfg, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind nmea_sentence_checksum_checker nsc_port_checker u_port_checker (.*);
